// ----- sv/pipeline_latency_tracker_top_assert.svh -----
// Assertion macros for the pipeline latency tracker top level.
`ifndef PIPELINE_LATENCY_TRACKER_TOP_ASSERT_SVH
`define PIPELINE_LATENCY_TRACKER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PTL_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("ptl assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PTL_ASSERT_NXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("ptl assertion failed");
`else
`define PTL_ASSERT_IMP(label, a, b)
`define PTL_ASSERT_NXT(label, a, b)
`endif
`endif

// ----- sv/ptl_pkg.sv -----
// Shared types and constants of the pipeline latency tracker.
`timescale 1ns / 1ps
package ptl_pkg;

    localparam int PTL_TABLE_ENTRIES = 16;

    localparam logic [2:0] ACT_CAPTURE  = 3'd0;
    localparam logic [2:0] ACT_ESTIMATE = 3'd1;
    localparam logic [2:0] ACT_CONTROL  = 3'd2;
    localparam logic [2:0] ACT_ACTUATE  = 3'd3;
    localparam logic [2:0] ACT_READ     = 3'd4;

    localparam logic CFG_MAX_AGE      = 1'b0;
    localparam logic CFG_MAX_INFLIGHT = 1'b1;

    localparam logic signed [48:0] SUM_MAX = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] SUM_MIN = -49'sh0_8000_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EVICT,
        ST_ALLOC,
        ST_STAMP,
        ST_AGE_RD,
        ST_AGE_CK,
        ST_CNT,
        ST_FIN,
        ST_TREAD,
        ST_LAT,
        ST_ACC,
        ST_OUT
    } ptl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_ALLOC,
        OP_STAMP,
        OP_AGE_RD,
        OP_DROP_OLD,
        OP_TREAD,
        OP_LAT,
        OP_ACC,
        OP_OUT
    } ptl_op_t;

    typedef struct packed {
        ptl_op_t op;
    } ptl_cmd_t;

    typedef struct packed {
        logic in_is_stamp;
        logic hit;
        logic scan_last;
        logic full;
        logic age_on;
        logic age_go;
        logic age_drop;
        logic cnt_drop;
        logic fin_ok;
        logic rd_last;
        logic acc_last;
        logic out_free;
    } ptl_status_t;

endpackage

// ----- sv/ptl_ctrl.sv -----
// Sequencer of the pipeline latency tracker: one request at a time.
`timescale 1ns / 1ps
module ptl_ctrl
    import ptl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  ptl_status_t status,
    output ptl_cmd_t    cmd
);

    ptl_state_t state_reg;
    ptl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = status.in_is_stamp ? ST_SEARCH : ST_OUT;
                end
            end
            ST_SEARCH:
            begin
                cmd.op = OP_SCAN;
                if (status.hit)
                    state_next = ST_STAMP;
                else if (status.scan_last)
                    state_next = status.full ? ST_EVICT : ST_ALLOC;
            end
            ST_EVICT:
            begin
                cmd.op     = OP_DROP_OLD;
                state_next = ST_ALLOC;
            end
            ST_ALLOC:
            begin
                cmd.op     = OP_ALLOC;
                state_next = ST_STAMP;
            end
            ST_STAMP:
            begin
                cmd.op     = OP_STAMP;
                state_next = status.age_on ? ST_AGE_RD : ST_CNT;
            end
            ST_AGE_RD:
            begin
                cmd.op     = OP_AGE_RD;
                state_next = status.age_go ? ST_AGE_CK : ST_CNT;
            end
            ST_AGE_CK:
            begin
                if (status.age_drop)
                begin
                    cmd.op     = OP_DROP_OLD;
                    state_next = ST_AGE_RD;
                end
                else
                begin
                    state_next = ST_CNT;
                end
            end
            ST_CNT:
            begin
                if (status.cnt_drop)
                    cmd.op = OP_DROP_OLD;
                else
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = status.fin_ok ? ST_TREAD : ST_OUT;
            end
            ST_TREAD:
            begin
                cmd.op = OP_TREAD;
                if (status.rd_last)
                    state_next = ST_LAT;
            end
            ST_LAT:
            begin
                cmd.op     = OP_LAT;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.op = OP_ACC;
                if (status.acc_last)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/ptl_dpath.sv -----
// Frame table, stamp memory, statistics and result register of the tracker.
`timescale 1ns / 1ps
module ptl_dpath
    import ptl_pkg::*;
#(
    parameter int TABLE_ENTRIES = PTL_TABLE_ENTRIES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ptl_cmd_t            cmd,
    output ptl_status_t         status,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [2:0]          action,
    input  logic [31:0]         frame_number,
    input  logic [31:0]         stamp_time,
    input  logic [1:0]          stat_segment,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                finalized,
    output logic signed [31:0]  total_latency,
    output logic signed [31:0]  vision_latency,
    output logic signed [31:0]  control_latency,
    output logic signed [31:0]  actuate_latency,
    output logic [4:0]          pruned_count,
    output logic [31:0]         completed_frames,
    output logic                stats_valid,
    output logic signed [31:0]  segment_min,
    output logic signed [31:0]  segment_max,
    output logic signed [47:0]  segment_sum
);

    localparam int SW = $clog2(TABLE_ENTRIES);
    localparam int LW = $clog2(TABLE_ENTRIES + 1);
    localparam int CW = (LW > 5) ? LW : 5;
    localparam int AW = SW + 2;
    localparam int MD = TABLE_ENTRIES * 4;

    // table control state
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [3:0]               present_reg [TABLE_ENTRIES];
    logic [LW-1:0]            live_reg;
    logic [31:0]              frame_reg   [TABLE_ENTRIES];
    logic [SW-1:0]            rank_reg    [TABLE_ENTRIES];
    logic [SW-1:0]            ord_reg     [TABLE_ENTRIES];
    logic [31:0]              mem         [MD];
    logic [31:0]              rdata_reg;

    // request registers
    logic [2:0]               act_reg;
    logic [31:0]              frm_reg;
    logic [31:0]              now_reg;
    logic [1:0]               seg_reg;
    logic [4:0]               pruned_reg;
    logic [SW-1:0]            slot_reg;
    logic [SW-1:0]            scan_reg;
    logic [2:0]               rd_reg;
    logic [1:0]               k_reg;
    logic                     fin_reg;
    logic [31:0]              t_reg       [4];
    logic signed [31:0]       lat_reg     [4];

    // statistics and configuration
    logic signed [31:0]       min_reg     [4];
    logic signed [31:0]       max_reg     [4];
    logic signed [47:0]       tot_reg     [4];
    logic                     started_reg;
    logic [31:0]              done_reg;
    logic [31:0]              max_age_reg;
    logic [4:0]               max_inf_reg;
    logic                     out_valid_reg;

    logic [SW-1:0]            free_idx;
    logic                     drop_en;
    logic [SW-1:0]            drop_slot;
    logic [SW-1:0]            drop_rank;
    logic [AW-1:0]            raddr;
    logic [31:0]              age;
    logic signed [48:0]       sum_raw;
    logic signed [48:0]       sum_sat;
    logic                     is_stamp;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                free_idx = SW'(i);
        end
    end

    assign drop_en   = (cmd.op == OP_DROP_OLD) || (cmd.op == OP_ACC && k_reg == 2'd3);
    assign drop_slot = (cmd.op == OP_DROP_OLD) ? ord_reg[0] : slot_reg;
    assign drop_rank = rank_reg[drop_slot];
    assign raddr     = (cmd.op == OP_TREAD) ? {slot_reg, rd_reg[1:0]} : {ord_reg[0], 2'b00};
    assign age       = now_reg - rdata_reg;
    assign sum_raw   = {tot_reg[k_reg][47], tot_reg[k_reg]} + 49'(lat_reg[k_reg]);
    assign sum_sat   = (sum_raw > SUM_MAX) ? SUM_MAX : ((sum_raw < SUM_MIN) ? SUM_MIN : sum_raw);

    always_comb
    begin
        is_stamp = (action inside {[ACT_CAPTURE:ACT_ACTUATE]});
    end

    always_comb
    begin
        status.in_is_stamp = is_stamp;
        status.hit         = valid_reg[scan_reg] && (frame_reg[scan_reg] == frm_reg);
        status.scan_last   = (scan_reg == SW'(TABLE_ENTRIES - 1));
        status.full        = (live_reg == LW'(TABLE_ENTRIES));
        status.age_on      = (max_age_reg != 32'd0);
        status.age_go      = (live_reg != '0) && present_reg[ord_reg[0]][0];
        status.age_drop    = !age[31] && (age != 32'd0) && (age > max_age_reg);
        status.cnt_drop    = (max_inf_reg != 5'd0) && (CW'(live_reg) > CW'(max_inf_reg));
        status.fin_ok      = valid_reg[slot_reg] && (present_reg[slot_reg] == 4'hF);
        status.rd_last     = (rd_reg == 3'd4);
        status.acc_last    = (k_reg == 2'd3);
        status.out_free    = !out_valid_reg || !out_stall;
    end

    // control state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            live_reg      <= '0;
            started_reg   <= 1'b0;
            done_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
            max_age_reg   <= 32'd0;
            max_inf_reg   <= 5'd0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                present_reg[i] <= 4'd0;
            for (int j = 0; j < 4; j++)
                tot_reg[j] <= 48'sd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_MAX_AGE)
                    max_age_reg <= cfg_data;
                else
                    max_inf_reg <= cfg_data[4:0];
            end
            case (cmd.op)
                OP_ALLOC:
                begin
                    valid_reg[free_idx]   <= 1'b1;
                    present_reg[free_idx] <= 4'd0;
                    live_reg              <= live_reg + 1'b1;
                end
                OP_STAMP:
                begin
                    present_reg[slot_reg][act_reg[1:0]] <= 1'b1;
                end
                OP_ACC:
                begin
                    tot_reg[k_reg] <= sum_sat[47:0];
                    if (k_reg == 2'd3)
                    begin
                        started_reg <= 1'b1;
                        if (done_reg != 32'hFFFF_FFFF)
                            done_reg <= done_reg + 32'd1;
                    end
                end
                default:
                begin
                end
            endcase
            if (drop_en)
            begin
                valid_reg[drop_slot]   <= 1'b0;
                present_reg[drop_slot] <= 4'd0;
                live_reg               <= live_reg - 1'b1;
            end
            if (cmd.op == OP_OUT)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                act_reg    <= action;
                frm_reg    <= frame_number;
                now_reg    <= stamp_time;
                seg_reg    <= stat_segment;
                pruned_reg <= 5'd0;
                fin_reg    <= 1'b0;
                scan_reg   <= '0;
                rd_reg     <= 3'd0;
                k_reg      <= 2'd0;
            end
            OP_SCAN:
            begin
                if (status.hit)
                    slot_reg <= scan_reg;
                scan_reg <= scan_reg + 1'b1;
            end
            OP_ALLOC:
            begin
                slot_reg                 <= free_idx;
                frame_reg[free_idx]      <= frm_reg;
                rank_reg[free_idx]       <= live_reg[SW-1:0];
                ord_reg[live_reg[SW-1:0]] <= free_idx;
            end
            OP_DROP_OLD:
            begin
                pruned_reg <= pruned_reg + 5'd1;
            end
            OP_TREAD:
            begin
                if (rd_reg != 3'd0)
                    t_reg[2'(rd_reg - 3'd1)] <= rdata_reg;
                rd_reg <= rd_reg + 3'd1;
            end
            OP_LAT:
            begin
                lat_reg[0] <= t_reg[3] - t_reg[0];
                lat_reg[1] <= t_reg[1] - t_reg[0];
                lat_reg[2] <= t_reg[2] - t_reg[1];
                lat_reg[3] <= t_reg[3] - t_reg[2];
            end
            OP_ACC:
            begin
                if (!started_reg || lat_reg[k_reg] < min_reg[k_reg])
                    min_reg[k_reg] <= lat_reg[k_reg];
                if (!started_reg || lat_reg[k_reg] > max_reg[k_reg])
                    max_reg[k_reg] <= lat_reg[k_reg];
                if (k_reg == 2'd3)
                    fin_reg <= 1'b1;
                k_reg <= k_reg + 2'd1;
            end
            OP_OUT:
            begin
                finalized        <= fin_reg;
                total_latency    <= fin_reg ? lat_reg[0] : 32'sd0;
                vision_latency   <= fin_reg ? lat_reg[1] : 32'sd0;
                control_latency  <= fin_reg ? lat_reg[2] : 32'sd0;
                actuate_latency  <= fin_reg ? lat_reg[3] : 32'sd0;
                pruned_count     <= pruned_reg;
                completed_frames <= done_reg;
                stats_valid      <= started_reg;
                if (act_reg == ACT_READ && started_reg)
                begin
                    segment_min <= min_reg[seg_reg];
                    segment_max <= max_reg[seg_reg];
                    segment_sum <= tot_reg[seg_reg];
                end
                else
                begin
                    segment_min <= 32'sd0;
                    segment_max <= 32'sd0;
                    segment_sum <= 48'sd0;
                end
            end
            default:
            begin
            end
        endcase
        if (drop_en)
        begin
            for (int p = 0; p < TABLE_ENTRIES - 1; p++)
            begin
                if (SW'(p) >= drop_rank)
                    ord_reg[p] <= ord_reg[p + 1];
            end
            for (int e = 0; e < TABLE_ENTRIES; e++)
            begin
                if (valid_reg[e] && rank_reg[e] > drop_rank)
                    rank_reg[e] <= rank_reg[e] - 1'b1;
            end
        end
    end

    // stamp memory: four words per slot
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_STAMP)
            mem[{slot_reg, act_reg[1:0]}] <= now_reg;
        rdata_reg <= mem[raddr];
    end

endmodule

// ----- sv/pipeline_latency_tracker_top.sv -----
// Top level of the pipeline latency tracker: sequencer plus datapath.
`timescale 1ns / 1ps
`include "pipeline_latency_tracker_top_assert.svh"
//
//  Channel   Handshake            Payload
//  in        in_valid/in_stall    action, frame_number, stamp_time, stat_segment
//  out       out_valid/out_stall  finalized, four latencies, counts, segment stats
//  cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  A stamp for a new frame passes search, allocation, stamp, count check and finish
//  to the result; the frame search walks one table entry per cycle and a hit ends it
//  early. Age pruning, when on, adds age reads and checks; an eviction and each entry
//  pruned add a drop step; a completed frame adds stamp reads, latency and fold, its
//  four stamps coming one a cycle from the stamp memory. A read request skips to output.
//  Reset clears the table and statistics at once.
//  A result waits in the output register while the next request is taken in;
//  a stalled output holds the block only when the following result is ready.
//
module pipeline_latency_tracker_top
    import ptl_pkg::*;
#(
    parameter int TABLE_ENTRIES = PTL_TABLE_ENTRIES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          action,
    input  logic [31:0]         frame_number,
    input  logic [31:0]         stamp_time,
    input  logic [1:0]          stat_segment,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                finalized,
    output logic signed [31:0]  total_latency,
    output logic signed [31:0]  vision_latency,
    output logic signed [31:0]  control_latency,
    output logic signed [31:0]  actuate_latency,
    output logic [4:0]          pruned_count,
    output logic [31:0]         completed_frames,
    output logic                stats_valid,
    output logic signed [31:0]  segment_min,
    output logic signed [31:0]  segment_max,
    output logic signed [47:0]  segment_sum,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    ptl_cmd_t    cmd;
    ptl_status_t status;

    // sequencer: walks each stamp request through search, stamp, prune and, once complete, fold
    ptl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: frame table, stamp memory, statistics, result register
    ptl_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .action           (action),
        .frame_number     (frame_number),
        .stamp_time       (stamp_time),
        .stat_segment     (stat_segment),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .finalized        (finalized),
        .total_latency    (total_latency),
        .vision_latency   (vision_latency),
        .control_latency  (control_latency),
        .actuate_latency  (actuate_latency),
        .pruned_count     (pruned_count),
        .completed_frames (completed_frames),
        .stats_valid      (stats_valid),
        .segment_min      (segment_min),
        .segment_max      (segment_max),
        .segment_sum      (segment_sum)
    );

    // hold off the next request once one is taken
    `PTL_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // a completed frame always shows up in the statistics
    `PTL_ASSERT_IMP(a_fin_has_stats, out_valid && finalized, stats_valid && completed_frames != 32'd0)
    // never allocate into a full table
    `PTL_ASSERT_IMP(a_alloc_not_full, cmd.op == OP_ALLOC, !status.full)

endmodule
